// File: hw/rtl/hca_pkg.sv
package hca_pkg;

    localparam int NumHandlesDef = 16;
    localparam int PoolBytesDef  = 4096;

    localparam logic [8:0] ThreshReset = 9'd192;

    localparam logic [2:0] FN_ALLOC    = 3'd0;
    localparam logic [2:0] FN_BIND     = 3'd1;
    localparam logic [2:0] FN_RESOLVE  = 3'd2;
    localparam logic [2:0] FN_LOCK     = 3'd3;
    localparam logic [2:0] FN_RELEASE  = 3'd4;
    localparam logic [2:0] FN_CPRESS   = 3'd5;
    localparam logic [2:0] FN_COMPACT  = 3'd6;
    localparam logic [2:0] FN_STATUS   = 3'd7;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BADARG   = 3'd1;
    localparam logic [2:0] ST_NOSPACE  = 3'd2;
    localparam logic [2:0] ST_NOHANDLE = 3'd3;
    localparam logic [2:0] ST_LOCKED   = 3'd4;
    localparam logic [2:0] ST_NOTUSED  = 3'd5;

    typedef struct packed {
        logic [2:0]  func;
        logic [3:0]  handle_id;
        logic [12:0] request_bytes;
        logic        lock_value;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  granted_handle;
        logic [11:0] block_offset;
        logic [12:0] block_bytes;
        logic [12:0] top_bytes;
        logic [15:0] live_bytes;
        logic [4:0]  live_handles;
        logic        did_compact;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_COMPACT,
        S_CHECK,
        S_SEARCH,
        S_CLAIM,
        S_COUNT,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;        // latch input item
        logic wk_clear;    // clear walk index and accumulators
        logic wk_step;     // advance walk one entry
        logic do_bind_pre; // release bound handle if unlocked
        logic do_simple;   // lock / release / resolve action
        logic do_claim;    // claim target slot
        logic set_nospace;
        logic set_nohandle;
        logic set_badarg;
        logic set_locked;
        logic set_notused;
        logic finish_out;  // register result
        logic cmp_pre;     // compaction walk step
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [2:0] func;
        logic       hok;
        logic       sok;
        logic       tgt_used;
        logic       tgt_locked;
        logic       fits;
        logic       pressure;
        logic       wk_last;
        logic       found;
    } t_sts;

endpackage

// File: hw/rtl/handle_compacting_allocator_top.sv
// Handle table allocator over a byte pool with a bump pointer and compaction.
// One item in flight at a time; input stall stays high from acceptance until
// the result is registered. Each walk over the handle table (compaction, free
// handle search, live count) visits one entry per cycle, and every item ends
// with the live count walk. The block returns to idle before the next item is
// taken. The threshold register may be written whenever the block is idle.
module handle_compacting_allocator_top
    import hca_pkg::*;
#(
    parameter int NUM_HANDLES = NumHandlesDef,
    parameter int POOL_BYTES  = PoolBytesDef
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_item,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_item,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [8:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    hca_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    hca_dpath #(
        .NUM_HANDLES (NUM_HANDLES),
        .POOL_BYTES  (POOL_BYTES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_in_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_item      (o_out_item)
    );

endmodule

// File: hw/rtl/hca_ctrl.sv
module hca_ctrl
    import hca_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  logic i_out_stall,
    output logic o_out_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    // 0: compaction is followed by the count walk, 1: by the op that needed the space
    logic   r_after_cmp, n_after_cmp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_after_cmp <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_after_cmp <= n_after_cmp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_in_stall  = (r_state != S_IDLE);

    logic accept;
    assign accept = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_after_cmp = r_after_cmp;
        unique case (r_state)
            S_IDLE: if (accept) n_state = S_DECODE;
            S_DECODE: begin
                n_after_cmp = 1'b0;
                unique case (i_sts.func)
                    FN_ALLOC: begin
                        if (!i_sts.sok) n_state = S_COUNT;
                        else if (i_sts.fits) n_state = S_SEARCH;
                        else begin
                            n_state = S_COMPACT;
                            n_after_cmp = 1'b1;
                        end
                    end
                    FN_BIND: begin
                        if (!i_sts.hok || !i_sts.sok) n_state = S_COUNT;
                        else if (i_sts.tgt_used && i_sts.tgt_locked) n_state = S_COUNT;
                        else n_state = S_CHECK;
                    end
                    FN_CPRESS: n_state = i_sts.pressure ? S_COMPACT : S_COUNT;
                    FN_COMPACT: n_state = S_COMPACT;
                    default: n_state = S_COUNT;
                endcase
            end
            S_CHECK: begin
                // bind after pre-release
                if (i_sts.fits) n_state = S_CLAIM;
                else begin
                    n_state = S_COMPACT;
                    n_after_cmp = 1'b1;
                end
            end
            S_COMPACT: if (i_sts.wk_last) begin
                if (!r_after_cmp) n_state = S_COUNT;
                else if (!i_sts.fits) n_state = S_COUNT;
                else if (i_sts.func == FN_ALLOC) n_state = S_SEARCH;
                else n_state = S_CLAIM;
            end
            S_SEARCH: begin
                if (i_sts.found) n_state = S_CLAIM;
                else if (i_sts.wk_last) n_state = S_COUNT;
            end
            S_CLAIM: n_state = S_COUNT;
            S_COUNT: if (i_sts.wk_last) n_state = S_OUT;
            S_OUT: if (!r_out_valid || !i_out_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) n_out_valid = 1'b0;
        if (r_state == S_OUT && (!r_out_valid || !i_out_stall)) n_out_valid = 1'b1;
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = accept;
            end
            S_DECODE: begin
                o_cmd.wk_clear = 1'b1;
                unique case (i_sts.func)
                    FN_ALLOC: o_cmd.set_badarg = !i_sts.sok;
                    FN_BIND: begin
                        if (!i_sts.hok || !i_sts.sok) o_cmd.set_badarg = 1'b1;
                        else if (i_sts.tgt_used && i_sts.tgt_locked) o_cmd.set_locked = 1'b1;
                        else o_cmd.do_bind_pre = 1'b1;
                    end
                    FN_RESOLVE, FN_LOCK, FN_RELEASE: begin
                        if (!i_sts.hok) o_cmd.set_badarg = 1'b1;
                        else if (!i_sts.tgt_used) o_cmd.set_notused = 1'b1;
                        else o_cmd.do_simple = 1'b1;
                    end
                    default: ;
                endcase
            end
            S_CHECK: o_cmd.wk_clear = 1'b1;
            S_COMPACT: begin
                o_cmd.wk_step = 1'b1;
                o_cmd.cmp_pre = 1'b1;
                if (i_sts.wk_last) begin
                    o_cmd.wk_clear = 1'b1;
                    o_cmd.set_nospace = r_after_cmp && !i_sts.fits;
                end
            end
            S_SEARCH: begin
                o_cmd.wk_step = 1'b1;
                if (i_sts.found || i_sts.wk_last) o_cmd.wk_clear = 1'b1;
                o_cmd.set_nohandle = !i_sts.found && i_sts.wk_last;
            end
            S_CLAIM: begin
                o_cmd.do_claim = 1'b1;
                o_cmd.wk_clear = 1'b1;
            end
            S_COUNT: o_cmd.wk_step = 1'b1;
            S_OUT: o_cmd.finish_out = !r_out_valid || !i_out_stall;
            default: ;
        endcase
    end

endmodule

// File: hw/rtl/hca_dpath.sv
module hca_dpath
    import hca_pkg::*;
#(
    parameter int NUM_HANDLES = NumHandlesDef,
    parameter int POOL_BYTES  = PoolBytesDef
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_item,
    input  logic      i_cfg_valid,
    input  logic [8:0] i_cfg_data,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    output t_out_item o_item
);

    localparam int HW = (NUM_HANDLES > 1) ? $clog2(NUM_HANDLES) : 1;
    localparam int CW = $clog2(NUM_HANDLES + 1);
    // wide enough for overcommitted totals
    localparam int TW = $clog2(POOL_BYTES * (NUM_HANDLES + 1) + 1);
    localparam logic [TW-1:0] PoolT = TW'(POOL_BYTES);
    localparam logic [TW-1:0] LastT = TW'(NUM_HANDLES - 1);

    logic [TW-1:0] r_off  [NUM_HANDLES];
    logic [12:0]   r_size [NUM_HANDLES];
    logic [NUM_HANDLES-1:0] r_used, r_lock;
    logic [TW-1:0] r_top;
    logic [8:0]    r_thr;

    t_in_item      r_in;
    logic [2:0]    r_status;
    logic          r_did;
    logic [3:0]    r_granted;
    logic [HW-1:0] r_idx;
    logic [TW-1:0] r_wp;
    logic [TW-1:0] r_live_b;
    logic [CW-1:0] r_live_h;
    t_out_item     r_out;

    logic [HW-1:0] hsel;
    logic          hok, sok;
    logic [TW-1:0] req_t;
    logic [TW+8:0] lhs, rhs;

    assign hsel  = HW'(r_in.handle_id);
    assign hok   = {28'd0, r_in.handle_id} < 32'(NUM_HANDLES);
    assign sok   = (r_in.request_bytes != 13'd0) && (TW'(r_in.request_bytes) <= PoolT);
    assign req_t = TW'(r_in.request_bytes);
    assign lhs   = (TW+9)'({r_top, 8'd0});
    assign rhs   = (TW+9)'(r_thr) * (TW+9)'(POOL_BYTES);

    assign o_sts.func       = r_in.func;
    assign o_sts.hok        = hok;
    assign o_sts.sok        = sok;
    assign o_sts.tgt_used   = hok && r_used[hsel];
    assign o_sts.tgt_locked = r_lock[hsel];
    // during compaction the new top is the running write pointer
    assign o_sts.fits       = ((i_cmd.cmp_pre ? r_wp + ((r_used[r_idx] && !r_lock[r_idx])
                                ? TW'(r_size[r_idx]) : '0) : r_top) + req_t) <= PoolT;
    assign o_sts.pressure   = lhs >= rhs;
    assign o_sts.wk_last    = TW'(r_idx) == LastT;
    assign o_sts.found      = !r_used[r_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_lock <= '0;
            r_top  <= '0;
            r_thr  <= ThreshReset;
            for (int k = 0; k < NUM_HANDLES; k++) r_size[k] <= '0;
        end else begin
            if (i_cfg_valid) r_thr <= i_cfg_data;
            if (i_cmd.do_bind_pre && r_used[hsel]) begin
                r_used[hsel] <= 1'b0;
                r_lock[hsel] <= 1'b0;
                r_size[hsel] <= '0;
            end
            if (i_cmd.do_simple) begin
                if (r_in.func == FN_LOCK) r_lock[hsel] <= r_in.lock_value;
                else if (r_in.func == FN_RELEASE) begin
                    r_used[hsel] <= 1'b0;
                    r_lock[hsel] <= 1'b0;
                    r_size[hsel] <= '0;
                end
            end
            if (i_cmd.cmp_pre) begin
                if (r_used[r_idx] && !r_lock[r_idx]) r_off[r_idx] <= r_wp;
                if (o_sts.wk_last)
                    r_top <= r_wp + ((r_used[r_idx] && !r_lock[r_idx])
                             ? TW'(r_size[r_idx]) : '0);
            end
            if (i_cmd.do_claim) begin
                r_off[r_granted[HW-1:0]]  <= r_top;
                r_size[r_granted[HW-1:0]] <= r_in.request_bytes;
                r_lock[r_granted[HW-1:0]] <= 1'b0;
                r_used[r_granted[HW-1:0]] <= 1'b1;
                r_top <= r_top + req_t;
            end
        end
    end

    logic          gvalid;
    logic [HW-1:0] gsel;
    assign gsel   = r_granted[HW-1:0];
    assign gvalid = ({28'd0, r_granted} < 32'(NUM_HANDLES)) && r_used[gsel];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in      <= i_item;
            r_status  <= ST_OK;
            r_did     <= 1'b0;
            r_granted <= (i_item.func == FN_ALLOC) ? 4'd0 : i_item.handle_id;
        end
        if (i_cmd.set_badarg)   r_status <= ST_BADARG;
        if (i_cmd.set_locked)   r_status <= ST_LOCKED;
        if (i_cmd.set_notused)  r_status <= ST_NOTUSED;
        if (i_cmd.set_nospace)  r_status <= ST_NOSPACE;
        if (i_cmd.set_nohandle) r_status <= ST_NOHANDLE;
        if (i_cmd.cmp_pre)      r_did    <= 1'b1;
        // free handle search stops at the first unused entry
        if (i_cmd.wk_step && i_cmd.wk_clear && !i_cmd.cmp_pre
            && r_in.func == FN_ALLOC && o_sts.found)
            r_granted <= 4'(r_idx);
        if (i_cmd.wk_clear) begin
            r_idx    <= '0;
            r_wp     <= '0;
            r_live_b <= '0;
            r_live_h <= '0;
        end else if (i_cmd.wk_step) begin
            r_idx <= r_idx + 1'b1;
            if (i_cmd.cmp_pre) begin
                if (r_used[r_idx] && !r_lock[r_idx]) r_wp <= r_wp + TW'(r_size[r_idx]);
            end else if (r_used[r_idx]) begin
                r_live_b <= r_live_b + TW'(r_size[r_idx]);
                r_live_h <= r_live_h + 1'b1;
            end
        end
        if (i_cmd.finish_out) begin
            r_out.status         <= r_status;
            r_out.granted_handle <= r_granted;
            r_out.block_offset   <= gvalid ? r_off[gsel][11:0] : 12'd0;
            r_out.block_bytes    <= gvalid ? r_size[gsel] : 13'd0;
            r_out.top_bytes      <= r_top[12:0];
            r_out.live_bytes     <= 16'(r_live_b);
            r_out.live_handles   <= 5'(r_live_h);
            r_out.did_compact    <= r_did;
        end
    end

    assign o_item = r_out;

endmodule
